// ===== rtl/bmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// bmfe_pkg: shared types and constants
// Bin table geometry, item codes, status codes, iterative unit command.
// ----------------------------------------------------------------------------
package bmfe_pkg;

  localparam int NUM_BINS           = 4096;
  localparam int MAX_PIXELS_PER_BIN = 65536;
  localparam int BIN_AW             = $clog2(NUM_BINS);
  localparam int CNT_W              = $clog2(MAX_PIXELS_PER_BIN + 1);
  localparam int SUM_W              = 40;
  localparam int PIX_W              = 24;
  localparam int IDX_W              = 12;

  // iterative unit widths
  localparam int NUM_W  = 42;            // dividend / radicand high part
  localparam int RAD_W  = 56;            // shift register for operand bits
  localparam int REM_W  = 43;
  localparam int DIV_STEPS  = 42;
  localparam int SQRT_STEPS = 28;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_QRY = 2'd1;
  localparam logic [1:0] KIND_CLR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOVAL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ZDEN  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } bin_entry_t;

  typedef struct packed {
    logic             start;
    logic             sqrt_mode;
    logic [RAD_W-1:0] num;      // operand bits, consumed from the top
    logic [NUM_W-1:0] divisor;
  } iter_cmd_t;

endpackage

// ===== rtl/bmfe_bin_mem.sv =====
// ----------------------------------------------------------------------------
// bmfe_bin_mem: bin table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmfe_bin_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bmfe_pkg::BIN_AW-1:0] waddr,
  input  bmfe_pkg::bin_entry_t       wdata,
  input  logic [bmfe_pkg::BIN_AW-1:0] raddr,
  output bmfe_pkg::bin_entry_t       rdata
);

  bmfe_pkg::bin_entry_t mem [bmfe_pkg::NUM_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bmfe_iter_unit.sv =====
// ----------------------------------------------------------------------------
// bmfe_iter_unit: shared restoring divider / square root
// One trial subtract per cycle; 42 steps for divide, 28 for square root.
// ----------------------------------------------------------------------------
module bmfe_iter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  bmfe_pkg::iter_cmd_t          cmd,
  output logic                         done,
  output logic [bmfe_pkg::NUM_W-1:0]   q
);

  logic                         run;
  logic                         sqrt_mode;
  logic [bmfe_pkg::STEP_W-1:0]  cnt;
  logic [bmfe_pkg::REM_W-1:0]   rem;
  logic [bmfe_pkg::RAD_W-1:0]   num;
  logic [bmfe_pkg::NUM_W-1:0]   divisor;

  logic [bmfe_pkg::REM_W-1:0]   rem_sh;
  logic [bmfe_pkg::REM_W-1:0]   sub;
  logic [bmfe_pkg::REM_W:0]     diff;
  logic                         take;

  always_comb begin
    if (sqrt_mode) begin
      rem_sh = {rem[bmfe_pkg::REM_W-3:0], num[bmfe_pkg::RAD_W-1 -: 2]};
      sub    = {q[bmfe_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[bmfe_pkg::REM_W-2:0], num[bmfe_pkg::RAD_W-1]};
      sub    = {1'b0, divisor};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    take = !diff[bmfe_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        run       <= 1'b1;
        sqrt_mode <= cmd.sqrt_mode;
        cnt       <= cmd.sqrt_mode ? bmfe_pkg::STEP_W'(bmfe_pkg::SQRT_STEPS - 1)
                                   : bmfe_pkg::STEP_W'(bmfe_pkg::DIV_STEPS - 1);
        rem       <= '0;
        q         <= '0;
        num       <= cmd.num;
        divisor   <= cmd.divisor;
      end else if (run) begin
        rem <= take ? diff[bmfe_pkg::REM_W-1:0] : rem_sh;
        q   <= {q[bmfe_pkg::NUM_W-2:0], take};
        num <= sqrt_mode ? {num[bmfe_pkg::RAD_W-3:0], 2'b00}
                         : {num[bmfe_pkg::RAD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bin_mean_and_fractional_error.sv =====
// ----------------------------------------------------------------------------
// bin_mean_and_fractional_error: per-bin sums with mean and error queries
// Accumulate and clear items pass through a table read, then a write.
// Queries use one shared trial-subtract unit, which runs a
// 42-step divide for the mean, a 28-step square root and a 42-step divide.
// Results leave through an output register; one item is in work at a time.
// After reset a clearing pass zeroes all 4096 bins of the table; no input is
// taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module bin_mean_and_fractional_error (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,     // background_level
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // bin_index[11:0], pixel_value[35:12], zero pad
  input  logic [2:0]  s_tuser,       // kind[1:0], pixel_valid[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,       // bin_mean[24:0], fractional_error[56:25], pad
  output logic [1:0]  m_tuser        // status[1:0]
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [42:0] MEAN_LIMIT = 43'd16777215;

  logic [3:0]                         state;
  logic [bmfe_pkg::BIN_AW-1:0]        clr_addr;
  logic [bmfe_pkg::PIX_W-1:0]         bg;
  logic [1:0]                         kind;
  logic [bmfe_pkg::IDX_W-1:0]         bin;
  logic [bmfe_pkg::PIX_W-1:0]         pix;
  logic                               pvalid;
  logic [bmfe_pkg::SUM_W-1:0]         s_r;
  logic [bmfe_pkg::CNT_W-1:0]         n_r;
  logic [bmfe_pkg::SUM_W:0]           bn;
  logic [24:0]                        mean;
  logic [31:0]                        ferr;
  logic [1:0]                         status;

  logic                               mem_we;
  logic [bmfe_pkg::BIN_AW-1:0]        mem_waddr;
  bmfe_pkg::bin_entry_t               mem_wdata;
  bmfe_pkg::bin_entry_t               mem_rdata;

  bmfe_pkg::iter_cmd_t                cmd;
  logic                               iter_done;
  logic [bmfe_pkg::NUM_W-1:0]         iter_q;

  logic                               in_range;
  logic [bmfe_pkg::SUM_W:0]           sum_add;
  logic [bmfe_pkg::NUM_W-1:0]         x_val;
  logic [bmfe_pkg::SUM_W:0]           mag;
  logic                               d_pos;
  logic [42:0]                        mean_diff;

  assign s_tready = (state == S_IDLE);
  assign in_range = ({1'b0, bin} < (bmfe_pkg::IDX_W + 1)'(bmfe_pkg::NUM_BINS));
  assign sum_add  = {1'b0, mem_rdata.sum} + (bmfe_pkg::SUM_W + 1)'(pix);
  assign d_pos    = ({1'b0, s_r} > bn);
  assign mag      = d_pos ? ({1'b0, s_r} - bn) : (bn - {1'b0, s_r});
  assign x_val    = bmfe_pkg::NUM_W'(s_r) + bmfe_pkg::NUM_W'(bn);
  assign mean_diff = {1'b0, iter_q} - 43'(bg);

  bmfe_bin_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (bin[bmfe_pkg::BIN_AW-1:0]),
    .rdata (mem_rdata)
  );

  bmfe_iter_unit u_iter (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (iter_done),
    .q    (iter_q)
  );

  // table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin[bmfe_pkg::BIN_AW-1:0];
    mem_wdata = '0;
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_EXEC && in_range) begin
      if (kind == bmfe_pkg::KIND_ACC) begin
        mem_we        = pvalid &&
                        (mem_rdata.cnt < bmfe_pkg::CNT_W'(bmfe_pkg::MAX_PIXELS_PER_BIN));
        mem_wdata.cnt = mem_rdata.cnt + 1'b1;
        mem_wdata.sum = sum_add[bmfe_pkg::SUM_W] ? '1 : sum_add[bmfe_pkg::SUM_W-1:0];
      end else if (kind == bmfe_pkg::KIND_CLR) begin
        mem_we = 1'b1;
      end
    end
  end

  // shared unit commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_MUL: begin
        cmd.start   = 1'b1;
        cmd.num     = {bmfe_pkg::NUM_W'({s_r, 1'b0}) + bmfe_pkg::NUM_W'(n_r), 14'd0};
        cmd.divisor = bmfe_pkg::NUM_W'({n_r, 1'b0});
      end
      S_DIV1: begin
        cmd.start     = iter_done && ({1'b0, s_r} != bn);
        cmd.sqrt_mode = 1'b1;
        cmd.num       = {x_val, 14'd0};
      end
      S_SQRT: begin
        cmd.start   = iter_done;
        cmd.num     = {bmfe_pkg::NUM_W'({iter_q[27:0], 13'd0}), 14'd0};
        cmd.divisor = bmfe_pkg::NUM_W'(mag);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      bg       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bg <= cfg_wdata;
      end
      // in S_FIN a taken result is replaced by the new one below
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == bmfe_pkg::BIN_AW'(bmfe_pkg::NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind   <= s_tuser[1:0];
            pvalid <= s_tuser[2];
            bin    <= s_tdata[11:0];
            pix    <= s_tdata[35:12];
            state  <= S_RD;
          end
        end
        S_RD: state <= S_EXEC;
        S_EXEC: begin
          s_r    <= mem_rdata.sum;
          n_r    <= mem_rdata.cnt;
          mean   <= '0;
          ferr   <= '0;
          if (kind != bmfe_pkg::KIND_QRY) begin
            state <= S_IDLE;
          end else if (!pvalid) begin
            status <= bmfe_pkg::ST_NOVAL;
            state  <= S_FIN;
          end else if (!in_range || mem_rdata.cnt == '0) begin
            status <= bmfe_pkg::ST_EMPTY;
            state  <= S_FIN;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          bn    <= (bmfe_pkg::SUM_W + 1)'(bg) * (bmfe_pkg::SUM_W + 1)'(n_r);
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (iter_done) begin
            mean <= (!mean_diff[42] && mean_diff > MEAN_LIMIT) ? 25'(MEAN_LIMIT)
                                                                 : mean_diff[24:0];
            if ({1'b0, s_r} == bn) begin
              status <= bmfe_pkg::ST_ZDEN;
              state  <= S_FIN;
            end else begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (iter_done) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (iter_done) begin
            status <= bmfe_pkg::ST_OK;
            if (d_pos) begin
              ferr <= (iter_q > bmfe_pkg::NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                 : iter_q[31:0];
            end else begin
              ferr <= (iter_q > bmfe_pkg::NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                                   : 32'(-iter_q[31:0]);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, ferr, mean};
            m_tuser  <= status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_RD)
    else $error("accepted transfer did not start a table read");

  a_iter_owner: assert property (@(posedge clk) disable iff (rst)
    iter_done |-> (state == S_DIV1 || state == S_SQRT || state == S_DIV2))
    else $error("shared unit finished outside a query");

  a_noval_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bmfe_pkg::ST_NOVAL || m_tuser == bmfe_pkg::ST_EMPTY)
      |-> m_tdata == '0)
    else $error("invalid or empty query carries nonzero data");

  a_zden_ferr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmfe_pkg::ST_ZDEN |-> m_tdata[56:25] == '0)
    else $error("zero denominator with nonzero error");

endmodule

// ===== dv/bmfe_checker.sv =====
// ----------------------------------------------------------------------------
// bmfe_checker: bin table predictor and result comparator
// Watches input and output transfers, keeps its own copy of the bin table
// and the background level, and checks each query result in order.
// ----------------------------------------------------------------------------
module bmfe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending,
  output int          seen_results
);

  typedef struct {
    logic [24:0] mean;
    logic [31:0] ferr;
    logic [1:0]  status;
  } bin_answer_t;

  logic [39:0] sum_tbl [bmfe_pkg::NUM_BINS];
  logic [16:0] cnt_tbl [bmfe_pkg::NUM_BINS];
  logic [23:0] bg_level;
  bin_answer_t answers_q[$];

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bin_answer_t query_bin(logic valid, logic [11:0] bin);
    bin_answer_t a;
    logic [63:0] s, n, bn, avg, x, mag, q;
    longint m;
    a.mean = '0;
    a.ferr = '0;
    if (!valid) begin
      a.status = bmfe_pkg::ST_NOVAL;
    end else if (cnt_tbl[bin] == 0) begin
      a.status = bmfe_pkg::ST_EMPTY;
    end else begin
      s = sum_tbl[bin];
      n = cnt_tbl[bin];
      bn = bg_level * n;
      avg = (2 * s + n) / (2 * n);
      m = longint'(avg) - longint'(bg_level);
      if (m > 16777215) m = 16777215;
      if (m < -16777215) m = -16777215;
      a.mean = m[24:0];
      if (s == bn) begin
        a.status = bmfe_pkg::ST_ZDEN;
      end else begin
        x = s + bn;
        mag = (s > bn) ? s - bn : bn - s;
        q = (isqrt64(x << 14) << 13) / mag;
        if (s > bn)
          a.ferr = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        else
          a.ferr = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        a.status = bmfe_pkg::ST_OK;
      end
    end
    return a;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = answers_q.size();

  always @(posedge clk) begin
    logic [1:0]  kind;
    logic [11:0] bin;
    logic [23:0] pix;
    logic [40:0] s;
    bin_answer_t w;
    if (rst) begin
      foreach (sum_tbl[i]) begin
        sum_tbl[i] = '0;
        cnt_tbl[i] = '0;
      end
      bg_level = '0;
      fail_count = 0;
      seen_results = 0;
      answers_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen_results++;
        if (answers_q.size() == 0) begin
          report("unexpected result", m_tdata, 0);
        end else begin
          w = answers_q.pop_front();
          if (m_tdata[24:0] !== w.mean) report("bin_mean", m_tdata[24:0], w.mean);
          if (m_tdata[56:25] !== w.ferr) report("fractional_error", m_tdata[56:25], w.ferr);
          if (m_tuser !== w.status) report("status", m_tuser, w.status);
        end
      end
      if (s_tvalid && s_tready) begin
        kind = s_tuser[1:0];
        bin = s_tdata[11:0];
        pix = s_tdata[35:12];
        case (kind)
          bmfe_pkg::KIND_ACC: begin
            if (s_tuser[2] && cnt_tbl[bin] < bmfe_pkg::MAX_PIXELS_PER_BIN) begin
              s = sum_tbl[bin] + pix;
              sum_tbl[bin] = s[40] ? '1 : s[39:0];
              cnt_tbl[bin] = cnt_tbl[bin] + 1;
            end
          end
          bmfe_pkg::KIND_CLR: begin
            sum_tbl[bin] = '0;
            cnt_tbl[bin] = '0;
          end
          bmfe_pkg::KIND_QRY: answers_q = {answers_q, query_bin(s_tuser[2], bin)};
          default: ;
        endcase
      end
      if (cfg_we) bg_level = cfg_wdata;
    end
  end

endmodule

// ===== dv/tb_bin_mean_and_fractional_error.sv =====
// ----------------------------------------------------------------------------
// tb_bin_mean_and_fractional_error: stimulus and verdict
// Directed corner items then random accumulate/query/clear traffic over a
// few hot bins, under three idling profiles and several background levels.
// ----------------------------------------------------------------------------
module tb_bin_mean_and_fractional_error;

  localparam logic [1:0] KIND_SPARE = 2'd3;   // unused item kind

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count;
  int          pending;
  int          seen_results;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  int          item_count;

  bin_mean_and_fractional_error i_dut (.*);

  bmfe_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver stall and cycle limit
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout");
      $display("bin_mean_and_fractional_error: mismatch");
      $finish;
    end
  end

  // tvalid stays up after a transfer unless the sender idles next
  task automatic send_item(logic [1:0] kind, logic [11:0] bin, logic [23:0] pix,
                           logic valid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, pix, bin};
    s_tuser  <= {valid, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item_count++;
  endtask

  task automatic set_background(logic [23:0] level);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int sidle, int ridle);
    logic [11:0] bin;
    int r;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) begin
      bin = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 55)
        send_item(bmfe_pkg::KIND_ACC, bin, ($urandom_range(3) == 0) ? 24'($urandom) :
                  24'($urandom_range(4095)), $urandom_range(9) != 0);
      else if (r < 90)
        send_item(bmfe_pkg::KIND_QRY, bin, 24'($urandom), $urandom_range(9) != 0);
      else if (r < 97)
        send_item(bmfe_pkg::KIND_CLR, bin, 24'($urandom), 1'($urandom));
      else
        send_item(KIND_SPARE, bin, 24'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    m_tready = 0;
    cycle_count = 0;
    item_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: empty, no value, extremes, zero denominator, out of use kind
    send_item(bmfe_pkg::KIND_QRY, 12'd5, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd5, 24'hFFFFFF, 1'b0);
    send_item(bmfe_pkg::KIND_ACC, 12'd5, 24'd0, 1'b0);
    send_item(bmfe_pkg::KIND_QRY, 12'd5, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_ACC, 12'hFFF, 24'hFFFFFF, 1'b1);
    send_item(bmfe_pkg::KIND_ACC, 12'hFFF, 24'hFFFFFF, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'hFFF, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_ACC, 12'd0, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd0, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_ACC, 12'd1, 24'd1, 1'b1);
    send_item(bmfe_pkg::KIND_ACC, 12'd1, 24'd2, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd1, 24'd0, 1'b1);
    send_item(KIND_SPARE, 12'd1, 24'd7, 1'b1);
    send_item(bmfe_pkg::KIND_CLR, 12'hFFF, 24'd0, 1'b0);
    send_item(bmfe_pkg::KIND_QRY, 12'hFFF, 24'd0, 1'b1);
    set_background(24'd256);
    send_item(bmfe_pkg::KIND_ACC, 12'd2, 24'd256, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd2, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd1, 24'd0, 1'b1);
    set_background(24'hFFFFFF);
    send_item(bmfe_pkg::KIND_QRY, 12'd1, 24'd0, 1'b1);
    send_item(bmfe_pkg::KIND_QRY, 12'd5, 24'd0, 1'b1);

    random_phase(130, 36, 69);
    set_background(24'($urandom_range(4095)));
    random_phase(130, 69, 36);
    set_background(24'd0);
    random_phase(70, 0, 0);
    set_background(24'($urandom_range(1023)));
    random_phase(70, 0, 0);

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d items sent, %0d query results checked, several background levels",
             item_count, seen_results);
    if (fail_count == 0)
      $display("bin_mean_and_fractional_error: match");
    else
      $display("bin_mean_and_fractional_error: mismatch");
    $finish;
  end

endmodule

// ===== bin_mean_and_fractional_error.f =====
rtl/bmfe_pkg.sv
rtl/bmfe_bin_mem.sv
rtl/bmfe_iter_unit.sv
rtl/bin_mean_and_fractional_error.sv
dv/bmfe_checker.sv
dv/tb_bin_mean_and_fractional_error.sv
